>>> hw/rtl/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants for the ray/box slab test
// Item structs for both channels and the fixed-point format constants.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int FracBits   = 16;
  localparam int CoordWidth = 32;

  typedef struct packed {
    logic signed [CoordWidth-1:0] origin_x;
    logic signed [CoordWidth-1:0] origin_y;
    logic signed [CoordWidth-1:0] origin_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_y;
    logic signed [CoordWidth-1:0] center_z;
    logic [CoordWidth-2:0]        extent_x;
    logic [CoordWidth-2:0]        extent_y;
    logic [CoordWidth-2:0]        extent_z;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] entry_dist;
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
  } out_item_t;

endpackage

>>> hw/rtl/rbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_div: pipelined fixed-point divider
// Computes (num << F) / den on magnitudes, one quotient bit per stage,
// truncated toward zero and saturated to the signed range. A side-band
// word travels with each item.
// ----------------------------------------------------------------------------
module rbs_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [W+1:0]   num,
  input  logic signed [W-1:0]   den,
  input  logic [SW-1:0]         side_in,
  output logic                  out_valid,
  output logic signed [W-1:0]   quo,
  output logic [SW-1:0]         side_out
);
  // Quotient bits needed: integer part up to W+1 bits (plus overflow), F frac.
  localparam int QB = W + 2 + F;
  localparam int NB = W + 2;

  logic            v   [1:QB];
  logic [NB-1:0]   rem [1:QB];
  logic [NB-1:0]   dd  [1:QB];
  logic [NB+F-1:0] nsh [1:QB];
  logic [QB-1:0]   q   [1:QB];
  logic            ng  [1:QB];
  logic [SW-1:0]   sd  [1:QB];

  logic [NB-1:0] nmag;
  logic [NB-1:0] dmag;
  assign nmag = num[W+1] ? NB'(-num) : NB'(num);
  assign dmag = den[W-1] ? NB'(-{{2{den[W-1]}}, den}) : NB'({2'b00, den});

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic            v_p, ng_p;
    logic [NB-1:0]   rem_p, dd_p;
    logic [NB+F-1:0] nsh_p;
    logic [QB-1:0]   q_p;
    logic [SW-1:0]   sd_p;
    logic [NB:0]     trial;
    logic [NB:0]     shifted;

    if (i == 0) begin : g_head
      assign v_p   = in_valid;
      assign rem_p = '0;
      assign dd_p  = dmag;
      assign nsh_p = {nmag, {F{1'b0}}};
      assign q_p   = '0;
      assign ng_p  = num[W+1] ^ den[W-1];
      assign sd_p  = side_in;
    end else begin : g_body
      assign v_p   = v[i];
      assign rem_p = rem[i];
      assign dd_p  = dd[i];
      assign nsh_p = nsh[i];
      assign q_p   = q[i];
      assign ng_p  = ng[i];
      assign sd_p  = sd[i];
    end

    assign shifted = {rem_p, nsh_p[NB+F-1]};
    assign trial   = shifted - {1'b0, dd_p};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v_p;
      end
      if (en) begin
        if (!trial[NB]) begin
          rem[i+1] <= trial[NB-1:0];
          q[i+1]   <= {q_p[QB-2:0], 1'b1};
        end else begin
          rem[i+1] <= shifted[NB-1:0];
          q[i+1]   <= {q_p[QB-2:0], 1'b0};
        end
        dd[i+1]  <= dd_p;
        nsh[i+1] <= {nsh_p[NB+F-2:0], 1'b0};
        ng[i+1]  <= ng_p;
        sd[i+1]  <= sd_p;
      end
    end
  end

  logic [QB-1:0] qf;
  logic          big;
  assign qf  = q[QB];
  assign big = |qf[QB-1:W-1];

  always_comb begin
    if (ng[QB]) begin
      if (big && qf != (QB'(1) << (W - 1))) quo = {1'b1, {(W-1){1'b0}}};
      else quo = W'(-qf);
    end else begin
      if (big) quo = {1'b0, {(W-1){1'b1}}};
      else quo = W'(qf);
    end
  end
  assign out_valid = v[QB];
  assign side_out  = sd[QB];
endmodule

>>> hw/rtl/rbs_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_axis: one axis of the slab test
// Forms the saturated corners, the two corner offsets, and divides both by
// the direction. Also reports whether a zero direction forces a miss.
// ----------------------------------------------------------------------------
module rbs_axis #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] org,
  input  logic signed [W-1:0] dir,
  input  logic signed [W-1:0] ctr,
  input  logic [W-2:0]        ext,
  output logic                out_valid,
  output logic signed [W-1:0] t_lo,
  output logic signed [W-1:0] t_hi,
  output logic                free,
  output logic                bad
);
  localparam logic signed [W+1:0] CMax = (W+2)'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [W+1:0] CMin = -CMax - 1;

  // Stage 1: corners.
  logic                v1;
  logic signed [W-1:0] lb, rt, o1, d1;
  logic signed [W+1:0] lbw, rtw;
  assign lbw = {{2{ctr[W-1]}}, ctr} - {3'b000, ext};
  assign rtw = {{2{ctr[W-1]}}, ctr} + {3'b000, ext};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      lb <= (lbw < CMin) ? W'(CMin) : W'(lbw);
      rt <= (rtw > CMax) ? W'(CMax) : W'(rtw);
      o1 <= org;
      d1 <= dir;
    end
  end

  // Stage 2: offsets and the zero-direction check.
  logic                v2;
  logic signed [W+1:0] n_lb, n_rt;
  logic signed [W-1:0] d2;
  logic                z2, b2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      n_lb <= {{2{lb[W-1]}}, lb} - {{2{o1[W-1]}}, o1};
      n_rt <= {{2{rt[W-1]}}, rt} - {{2{o1[W-1]}}, o1};
      z2   <= (d1 == '0);
      b2   <= (d1 == '0) && (o1 < lb || o1 > rt);
      // A zero divisor is replaced by one; the result is ignored.
      d2   <= (d1 == '0) ? W'(1) : d1;
    end
  end

  logic signed [W-1:0] q1, q2;
  logic                s1, s2;
  logic                ov1, ov2;

  // The zero-direction flag rides with one divider, the miss flag with the other.
  rbs_div #(.W(W), .F(F), .SW(1)) u_div_lb (
    .clk, .rst, .en, .in_valid(v2), .num(n_lb), .den(d2),
    .side_in(z2), .out_valid(ov1), .quo(q1), .side_out(s1)
  );
  rbs_div #(.W(W), .F(F), .SW(1)) u_div_rt (
    .clk, .rst, .en, .in_valid(v2), .num(n_rt), .den(d2),
    .side_in(b2), .out_valid(ov2), .quo(q2), .side_out(s2)
  );

  // Output stage: order the two slab distances.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= ov1 && ov2;
    if (en) begin
      t_lo <= (q1 < q2) ? q1 : q2;
      t_hi <= (q1 < q2) ? q2 : q1;
      free <= s1;
      bad  <= s2;
    end
  end
endmodule

>>> hw/rtl/rbs_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_point: point along the ray
// Computes origin + (entry * dir >> F), saturated, in two stages.
// ----------------------------------------------------------------------------
module rbs_point #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] t,
  input  logic signed [W-1:0] dir,
  input  logic signed [W-1:0] org,
  output logic signed [W-1:0] pt
);
  localparam logic signed [W+1:0] CMax = (W+2)'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [W+1:0] CMin = -CMax - 1;

  logic [W-1:0] tm, dm;
  assign tm = t[W-1] ? W'(-t) : W'(t);
  assign dm = dir[W-1] ? W'(-dir) : W'(dir);

  logic [2*W-1:0]      prod;
  logic                neg;
  logic signed [W-1:0] o1;
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= tm * dm;
      neg  <= t[W-1] ^ dir[W-1];
      o1   <= org;
    end
  end

  logic [2*W-F-1:0]    sh;
  logic signed [W-1:0] m;
  logic                sat;
  assign sh  = prod[2*W-1:F];
  assign sat = |sh[2*W-F-1:W-1];
  always_comb begin
    if (neg) begin
      if (sat && sh != ((2*W-F)'(1) << (W - 1))) m = {1'b1, {(W-1){1'b0}}};
      else m = W'(-sh);
    end else begin
      if (sat) m = {1'b0, {(W-1){1'b1}}};
      else m = W'(sh);
    end
  end

  logic signed [W+1:0] s;
  assign s = {{2{o1[W-1]}}, o1} + {{2{m[W-1]}}, m};
  always_ff @(posedge clk) begin
    if (en) pt <= (s > CMax) ? W'(CMax) : (s < CMin) ? W'(CMin) : W'(s);
  end
endmodule

>>> hw/rtl/ray_box_slab_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: fixed-point ray against axis-aligned box
// Slab test with pipelined dividers and a multiply stage for the point.
// ----------------------------------------------------------------------------
//  channel  | signals                      | direction
//  ---------+------------------------------+----------
//  in       | in_valid, in_stall, in_data  | input item
//  out      | out_valid, out_stall, out_data| result item
//
// One item is accepted per cycle while the output is not stalled; the
// depth is set by the bit-per-stage dividers. The whole pipeline advances
// only when its last stage is empty or being taken, so a stall freezes
// every stage. Reset clears the valid bits only.
module ray_box_slab_intersect_top #(
  parameter int FRAC_BITS = rbs_pkg::FracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rbs_pkg::out_item_t out_data
);
  import rbs_pkg::*;
  localparam int W = CoordWidth;
  localparam int F = FRAC_BITS;
  localparam int DL = W + 2 + F + 3;   // axis unit latency

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [W-1:0] org [3], dir [3];
  assign org[0] = W'(in_data.origin_x);
  assign org[1] = W'(in_data.origin_y);
  assign org[2] = W'(in_data.origin_z);
  assign dir[0] = W'(in_data.dir_x);
  assign dir[1] = W'(in_data.dir_y);
  assign dir[2] = W'(in_data.dir_z);
  logic signed [W-1:0] ctr [3];
  logic [W-2:0] ext [3];
  assign ctr[0] = W'(in_data.center_x);
  assign ctr[1] = W'(in_data.center_y);
  assign ctr[2] = W'(in_data.center_z);
  assign ext[0] = (W-1)'(in_data.extent_x);
  assign ext[1] = (W-1)'(in_data.extent_y);
  assign ext[2] = (W-1)'(in_data.extent_z);

  logic                av [3];
  logic signed [W-1:0] tlo [3], thi [3];
  logic                fr [3], bd [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_axis #(.W(W), .F(F)) u_axis (
      .clk, .rst, .en, .in_valid(in_valid), .org(org[a]), .dir(dir[a]),
      .ctr(ctr[a]), .ext(ext[a]), .out_valid(av[a]), .t_lo(tlo[a]),
      .t_hi(thi[a]), .free(fr[a]), .bad(bd[a])
    );
  end

  // Delay line for origin and direction alongside the axis units.
  logic [6*W-1:0] dly_in;
  logic [6*W-1:0] dly [DL];
  assign dly_in = {org[0], org[1], org[2], dir[0], dir[1], dir[2]};
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= dly_in;
      for (int i = 1; i < DL; i++) dly[i] <= dly[i-1];
    end
  end

  localparam logic signed [W-1:0] TMin = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] TMax = {1'b0, {(W-1){1'b1}}};

  // Combine stage: entry/exit reduction.
  logic signed [W-1:0] ent_c, ext_c;
  logic                bad_c;
  always_comb begin
    ent_c = TMin;
    ext_c = TMax;
    bad_c = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (bd[a]) bad_c = 1'b1;
      if (!fr[a]) begin
        if (tlo[a] > ent_c) ent_c = tlo[a];
        if (thi[a] < ext_c) ext_c = thi[a];
      end
    end
  end

  logic                cv, chit;
  logic signed [W-1:0] cent;
  logic [6*W-1:0]      cod;
  always_ff @(posedge clk) begin
    if (rst) cv <= 1'b0;
    else if (en) cv <= av[0] && av[1] && av[2];
    if (en) begin
      chit <= !bad_c && !ext_c[W-1] && (ent_c <= ext_c);
      cent <= ent_c;
      cod  <= dly[DL-1];
    end
  end

  logic signed [W-1:0] pt [3];
  for (genvar a = 0; a < 3; a++) begin : g_pt
    rbs_point #(.W(W), .F(F)) u_pt (
      .clk, .en, .t(cent), .dir(cod[(2-a)*W +: W]), .org(cod[(5-a)*W +: W]),
      .pt(pt[a])
    );
  end

  logic [1:0]          pv, ph;
  logic signed [W-1:0] pe [2];
  always_ff @(posedge clk) begin
    if (rst) pv <= '0;
    else if (en) pv <= {pv[0], cv};
    if (en) begin
      ph    <= {ph[0], chit};
      pe[0] <= cent;
      pe[1] <= pe[0];
    end
  end

  assign out_valid           = pv[1];
  assign out_data.hit        = ph[1];
  assign out_data.entry_dist = ph[1] ? W'(pe[1]) : '0;
  assign out_data.point_x    = ph[1] ? W'(pt[0]) : '0;
  assign out_data.point_y    = ph[1] ? W'(pt[1]) : '0;
  assign out_data.point_z    = ph[1] ? W'(pt[2]) : '0;
endmodule

>>> tb/sv/ray_box_slab_intersect_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top_tb: self-checking bench for the slab test
// Drives rays and boxes, predicts hit, entry distance and point in fixed
// point, and compares each result item in order with the prediction.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top_tb;
  import rbs_pkg::*;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint CLIM = 64'sd2147483648;
  localparam int     LATENCY = 56;

  class hit_scoreboard;
    out_item_t pending[$];
    int        mismatches;

    function longint clamp_c(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
    endfunction

    function longint from_mag(longint unsigned m, bit neg);
      if (neg) return (m >= CLIM) ? CMIN : -longint'(m);
      return (m >= CLIM) ? CMAX : longint'(m);
    endfunction

    // Quotient (num << F) / den, exact on magnitudes, truncated, saturated.
    function longint slab_div(longint num, longint den);
      bit neg;
      longint unsigned n, d, q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      q = n / d;
      if (q > (CLIM >> FracBits)) return neg ? CMIN : CMAX;
      q = (n << FracBits) / d;
      return from_mag(q, neg);
    endfunction

    function longint scale_mul(longint a, longint b);
      bit neg;
      logic [127:0] p;
      p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      neg = (a < 0) != (b < 0);
      p = p >> FracBits;
      if (p[127:64] != 0) return neg ? CMIN : CMAX;
      return from_mag(p[63:0], neg);
    endfunction

    function void note_ray(in_item_t it);
      longint org[3], dr[3], lb[3], rt[3], c, e, t1, t2, lo, hi;
      longint entry, exit_d;
      bit ok;
      out_item_t r;
      org = '{it.origin_x, it.origin_y, it.origin_z};
      dr = '{it.dir_x, it.dir_y, it.dir_z};
      entry = CMIN;
      exit_d = CMAX;
      ok = 1;
      for (int a = 0; a < 3; a++) begin
        c = a == 0 ? longint'(it.center_x) : a == 1 ? longint'(it.center_y)
                                                    : longint'(it.center_z);
        e = a == 0 ? longint'(it.extent_x) : a == 1 ? longint'(it.extent_y)
                                                    : longint'(it.extent_z);
        lb[a] = clamp_c(c - e);
        rt[a] = clamp_c(c + e);
        if (dr[a] == 0) begin
          if (org[a] < lb[a] || org[a] > rt[a]) ok = 0;
        end else begin
          t1 = slab_div(lb[a] - org[a], dr[a]);
          t2 = slab_div(rt[a] - org[a], dr[a]);
          lo = t1 < t2 ? t1 : t2;
          hi = t1 < t2 ? t2 : t1;
          if (lo > entry) entry = lo;
          if (hi < exit_d) exit_d = hi;
        end
      end
      r = '0;
      if (ok && exit_d >= 0 && entry <= exit_d) begin
        r.hit = 1'b1;
        r.entry_dist = entry[31:0];
        r.point_x = 32'(clamp_c(org[0] + scale_mul(entry, dr[0])));
        r.point_y = 32'(clamp_c(org[1] + scale_mul(entry, dr[1])));
        r.point_z = 32'(clamp_c(org[2] + scale_mul(entry, dr[2])));
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: hit %b/%b entry %h/%h point %h %h %h / %h %h %h",
                   want.hit, got.hit, want.entry_dist, got.entry_dist,
                   want.point_x, want.point_y, want.point_z,
                   got.point_x, got.point_y, got.point_z);
      end
    endfunction
  endclass

  logic      clk, rst, in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  int        send_idle_pct, recv_idle_pct;
  int        hold_cycles, hold_len;
  hit_scoreboard sb;

  ray_box_slab_intersect_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("ray_box_slab_intersect_top_tb: errors");
    $finish;
  end

  function logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function logic [30:0] pick_extent();
    case ($urandom_range(0, 6))
      0: return 31'h7fff_ffff;
      1: return 31'h0;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  function logic [31:0] pick_dir();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom;
      4: return 32'($signed($urandom_range(0, 32)) - 16);
      default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  // Mostly rays aimed at a box centred on origin + 4 * dir so that hits are common.
  function in_item_t random_ray();
    in_item_t it;
    it.origin_x = pick_coord(); it.origin_y = pick_coord(); it.origin_z = pick_coord();
    it.dir_x = pick_dir(); it.dir_y = pick_dir(); it.dir_z = pick_dir();
    it.extent_x = pick_extent(); it.extent_y = pick_extent(); it.extent_z = pick_extent();
    if ($urandom_range(0, 2) != 0) begin
      it.center_x = 32'($signed(it.origin_x) + $signed(it.dir_x) * 4);
      it.center_y = 32'($signed(it.origin_y) + $signed(it.dir_y) * 4);
      it.center_z = 32'($signed(it.origin_z) + $signed(it.dir_z) * 4);
    end else begin
      it.center_x = pick_coord(); it.center_y = pick_coord(); it.center_z = pick_coord();
    end
    return it;
  endfunction

  // Valid stays high after an accepted item until the next idle cycle or drain.
  task automatic send_ray(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_ray(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (hold_cycles < hold_len) begin
        hold_cycles <= hold_cycles + 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct;
      end
    end
  end

  initial begin
    in_item_t it;
    sb = new();
    rst = 1; in_valid = 0; in_data = '0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_len = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero directions, origin inside and outside.
    for (int k = 0; k < 20; k++) begin
      it = '0;
      it.extent_x = 31'h0001_0000; it.extent_y = 31'h0001_0000; it.extent_z = 31'h0001_0000;
      case (k)
        0: ;
        1: it.origin_x = 32'h0002_0000;
        2: begin it.dir_x = 32'h0001_0000; it.origin_x = 32'hfffb_0000; end
        3: begin it.dir_x = 32'hffff_0000; it.origin_x = 32'hfffb_0000; end
        4: begin it.dir_x = 32'h8000_0000; it.dir_y = 32'h7fff_ffff; it.dir_z = 32'h1; end
        5: begin
          it.origin_x = 32'h7fff_ffff; it.origin_y = 32'h8000_0000;
          it.origin_z = 32'h7fff_ffff; it.center_x = 32'h8000_0000;
          it.center_y = 32'h7fff_ffff; it.center_z = 32'h8000_0000;
          it.dir_x = 32'h1; it.dir_y = 32'hffff_ffff; it.dir_z = 32'h1;
          it.extent_x = '1; it.extent_y = '1; it.extent_z = '1;
        end
        6: begin it.extent_x = '1; it.extent_y = '1; it.extent_z = '1;
                 it.center_x = 32'h7fff_ffff; it.dir_z = 32'h0000_0001; end
        7: begin it.dir_x = 32'h0001_0000; it.dir_y = 32'h0001_0000;
                 it.origin_x = 32'hfffe_0000; it.origin_y = 32'hfff0_0000; end
        8: begin it.dir_x = 32'h0000_0001; it.origin_x = 32'h8000_0000; end
        9: begin it.dir_y = 32'hffff_ffff; it.origin_y = 32'h7fff_ffff;
                 it.extent_y = '0; end
        default: it = random_ray();
      endcase
      send_ray(it);
    end
    drain_results();

    send_idle_pct = 30; recv_idle_pct = 64;
    for (int k = 0; k < 280; k++) send_ray(random_ray());
    // The receiver holds off while the sender keeps offering items.
    hold_len = 300;
    for (int k = 0; k < 100; k++) send_ray(random_ray());
    drain_results();

    send_idle_pct = 64; recv_idle_pct = 30;
    for (int k = 0; k < 230; k++) send_ray(random_ray());
    drain_results();

    send_idle_pct = 0; recv_idle_pct = 0;
    for (int k = 0; k < 230; k++) send_ray(random_ray());

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ray_box_slab_intersect_top_tb: clean");
    end else begin
      $display("ray_box_slab_intersect_top_tb: errors");
    end
    $finish;
  end

endmodule
